// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check gated off while reset is asserted
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define ASSERT_CLK(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_CLK(name, clk, prop, msg)
`endif
`endif

// ----- src/ffba_pkg.sv -----
package ffba_pkg;

  // fixed field widths of the channels
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned PAGE_OUT_W  = 3;
  localparam int unsigned BLOCK_OUT_W = 6;
  localparam int unsigned ID_OUT_W    = 10;

  // presence lookup span; page numbers wrap modulo this span
  localparam int unsigned MASK_SPAN   = 64;
  localparam int unsigned MASK_SPAN_W = 6;

  localparam int unsigned DEF_PAGES           = 8;
  localparam int unsigned DEF_BLOCKS_PER_PAGE = 64;
  localparam int unsigned DEF_ID_BITS         = 10;

endpackage

// ----- src/first_fit_block_run_allocator.sv -----
// First-fit contiguous block allocator.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_page_present_mask_i) sets which
// pages are searched; it is always ready and must only be written while idle.
// Request channel (in_valid_i/in_stall_o, block_count_i) takes one beat per
// request; in_stall_o is low only when no request is in progress.
// Result channel (out_valid_o/out_stall_i) gives one beat per request:
// granted, page, first block and owner id, all zero on failure.
// A zero or oversized count is answered without a search. Any other request
// makes one pass over the owner table through its single read port, marking
// used ids and looking for the run, one pass over the id map to pick the
// smallest free id while clearing it, then, when a run is granted, one write
// per block.
// One request is worked on at a time; the next is taken while the result beat
// still waits, and a held result only delays the end of the next request.
// After reset both memories are cleared, with requests stalled.
`include "assert_macros.svh"

module first_fit_block_run_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned PAGES           = DEF_PAGES,
  parameter int unsigned BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE,
  parameter int unsigned ID_BITS         = DEF_ID_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [MASK_W-1:0]      cfg_page_present_mask_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CNT_W-1:0]       block_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   granted_o,
  output logic [PAGE_OUT_W-1:0]  page_index_o,
  output logic [BLOCK_OUT_W-1:0] first_block_o,
  output logic [ID_OUT_W-1:0]    owner_id_o
);

  localparam int unsigned TBL_DEPTH = PAGES * BLOCKS_PER_PAGE;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned ID_DEPTH  = 2 ** ID_BITS;
  localparam int unsigned PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned BLK_W     = $clog2(BLOCKS_PER_PAGE);
  localparam int unsigned RUN_W     = $clog2(BLOCKS_PER_PAGE + 1);
  localparam int unsigned CLR_DEPTH = (TBL_DEPTH > ID_DEPTH) ? TBL_DEPTH : ID_DEPTH;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_DECIDE,
    ST_STAMP,
    ST_RESULT
  } state_e;

  state_e                 state_q;
  logic [CLR_W-1:0]       clr_cnt_q;
  logic [MASK_W-1:0]      mask_q;
  logic [CNT_W-1:0]       count_q;

  // table scan issue side
  logic [TBL_AW-1:0]      scan_addr_q;
  logic [PAGE_W-1:0]      scan_page_q;
  logic [BLK_W-1:0]       scan_blk_q;

  // table scan return side
  logic                   rd_vld_q;
  logic [TBL_AW-1:0]      rd_addr_q;
  logic [PAGE_W-1:0]      rd_page_q;
  logic [BLK_W-1:0]       rd_blk_q;

  logic [RUN_W-1:0]       run_q;
  logic                   run_found_q;
  logic [PAGE_W-1:0]      run_page_q;
  logic [BLK_W-1:0]       run_blk_q;
  logic [TBL_AW-1:0]      run_addr_q;

  // id map sweep
  logic [ID_BITS-1:0]     id_cnt_q;
  logic                   id_vld_q;
  logic [ID_BITS-1:0]     id_addr_q;
  logic                   id_found_q;
  logic [ID_BITS-1:0]     id_val_q;

  logic [TBL_AW-1:0]      stamp_addr_q;
  logic [CNT_W-1:0]       stamp_left_q;

  logic                   out_valid_q;
  logic                   granted_q;
  logic [PAGE_OUT_W-1:0]  page_index_q;
  logic [BLOCK_OUT_W-1:0] first_block_q;
  logic [ID_OUT_W-1:0]    owner_id_q;

  // memory ports
  logic                   tbl_we;
  logic [TBL_AW-1:0]      tbl_waddr;
  logic [ID_BITS-1:0]     tbl_wdata;
  logic                   tbl_re;
  logic [ID_BITS-1:0]     tbl_rdata;
  logic                   idm_we;
  logic [ID_BITS-1:0]     idm_waddr;
  logic                   idm_wdata;
  logic                   idm_re;
  logic                   idm_rdata;

  logic [MASK_SPAN-1:0]   mask_ext;
  logic                   rd_present;
  logic [RUN_W-1:0]       run_base;
  logic [RUN_W-1:0]       run_next;
  logic                   run_hit;
  logic                   id_hit;
  logic                   bad_count;
  logic                   grant_ok;

  ffba_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (scan_addr_q),
    .rdata_o (tbl_rdata)
  );

  ffba_ram #(
    .WIDTH (1),
    .DEPTH (ID_DEPTH)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (idm_we),
    .waddr_i (idm_waddr),
    .wdata_i (idm_wdata),
    .re_i    (idm_re),
    .raddr_i (id_cnt_q),
    .rdata_o (idm_rdata)
  );

  always_comb begin
    mask_ext   = MASK_SPAN'(mask_q);
    rd_present = mask_ext[MASK_SPAN_W'(rd_page_q)];
    // a run never carries over a page start
    run_base   = (rd_blk_q == '0) ? '0 : run_q;
    run_next   = (tbl_rdata == '0) ? RUN_W'(run_base + RUN_W'(1)) : '0;
    run_hit    = rd_vld_q && rd_present && (tbl_rdata == '0) && !run_found_q &&
                 (32'(run_next) == 32'(count_q));
    id_hit     = id_vld_q && (id_addr_q != '0) && !idm_rdata && !id_found_q;
    bad_count  = (block_count_i == '0) || (32'(block_count_i) > BLOCKS_PER_PAGE);
    grant_ok   = run_found_q && id_found_q;
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = stamp_addr_q;
    tbl_wdata = id_val_q;
    tbl_re    = (state_q == ST_SCAN);
    idm_we    = 1'b0;
    idm_waddr = id_cnt_q;
    idm_wdata = 1'b0;
    idm_re    = (state_q == ST_SWEEP);
    if (state_q == ST_CLEAR) begin
      tbl_we    = (32'(clr_cnt_q) < TBL_DEPTH);
      tbl_waddr = TBL_AW'(clr_cnt_q);
      tbl_wdata = '0;
      idm_we    = (32'(clr_cnt_q) < ID_DEPTH);
      idm_waddr = ID_BITS'(clr_cnt_q);
    end else if (state_q == ST_STAMP) begin
      tbl_we = 1'b1;
    end
    if (rd_vld_q && rd_present) begin
      // mark the id found in this entry as used
      idm_we    = 1'b1;
      idm_waddr = tbl_rdata;
      idm_wdata = 1'b1;
    end else if (state_q == ST_SWEEP) begin
      // clear behind the read so the map is empty for the next request
      idm_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      mask_q        <= '0;
      count_q       <= '0;
      scan_addr_q   <= '0;
      scan_page_q   <= '0;
      scan_blk_q    <= '0;
      rd_vld_q      <= 1'b0;
      rd_addr_q     <= '0;
      rd_page_q     <= '0;
      rd_blk_q      <= '0;
      run_q         <= '0;
      run_found_q   <= 1'b0;
      run_page_q    <= '0;
      run_blk_q     <= '0;
      run_addr_q    <= '0;
      id_cnt_q      <= '0;
      id_vld_q      <= 1'b0;
      id_addr_q     <= '0;
      id_found_q    <= 1'b0;
      id_val_q      <= '0;
      stamp_addr_q  <= '0;
      stamp_left_q  <= '0;
      out_valid_q   <= 1'b0;
      granted_q     <= 1'b0;
      page_index_q  <= '0;
      first_block_q <= '0;
      owner_id_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_page_present_mask_i;
      end
      // in the result state the beat register is handled below
      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      rd_vld_q  <= (state_q == ST_SCAN);
      rd_addr_q <= scan_addr_q;
      rd_page_q <= scan_page_q;
      rd_blk_q  <= scan_blk_q;
      id_vld_q  <= (state_q == ST_SWEEP);
      id_addr_q <= id_cnt_q;

      if (rd_vld_q && rd_present) begin
        run_q <= run_next;
      end
      if (run_hit) begin
        run_found_q <= 1'b1;
        run_page_q  <= rd_page_q;
        run_blk_q   <= BLK_W'(32'(rd_blk_q) + 32'd1 - 32'(count_q));
        run_addr_q  <= TBL_AW'(32'(rd_addr_q) + 32'd1 - 32'(count_q));
      end
      if (id_hit) begin
        id_found_q <= 1'b1;
        id_val_q   <= id_addr_q;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= CLR_W'(clr_cnt_q + CLR_W'(1));
          if (32'(clr_cnt_q) == CLR_DEPTH - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            count_q     <= block_count_i;
            run_found_q <= 1'b0;
            id_found_q  <= 1'b0;
            run_q       <= '0;
            scan_addr_q <= '0;
            scan_page_q <= '0;
            scan_blk_q  <= '0;
            id_cnt_q    <= '0;
            state_q     <= bad_count ? ST_RESULT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_addr_q <= TBL_AW'(scan_addr_q + TBL_AW'(1));
          if (32'(scan_blk_q) == BLOCKS_PER_PAGE - 1) begin
            scan_blk_q  <= '0;
            scan_page_q <= PAGE_W'(scan_page_q + PAGE_W'(1));
          end else begin
            scan_blk_q <= BLK_W'(scan_blk_q + BLK_W'(1));
          end
          if (32'(scan_addr_q) == TBL_DEPTH - 1) begin
            state_q <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          id_cnt_q <= ID_BITS'(id_cnt_q + ID_BITS'(1));
          if (id_cnt_q == '1) begin
            state_q <= ST_SWEEP_END;
          end
        end
        ST_SWEEP_END: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          stamp_addr_q <= run_addr_q;
          stamp_left_q <= count_q;
          state_q      <= grant_ok ? ST_STAMP : ST_RESULT;
        end
        ST_STAMP: begin
          stamp_addr_q <= TBL_AW'(stamp_addr_q + TBL_AW'(1));
          stamp_left_q <= CNT_W'(stamp_left_q - CNT_W'(1));
          if (stamp_left_q == CNT_W'(1)) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            granted_q     <= grant_ok;
            page_index_q  <= grant_ok ? PAGE_OUT_W'(run_page_q) : '0;
            first_block_q <= grant_ok ? BLOCK_OUT_W'(run_blk_q) : '0;
            owner_id_q    <= grant_ok ? ID_OUT_W'(id_val_q) : '0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign page_index_o  = page_index_q;
  assign first_block_o = first_block_q;
  assign owner_id_o    = owner_id_q;

  `ASSERT_RST(a_stamp_nonzero, clk_i, rst_ni, (state_q == ST_STAMP) |-> (tbl_wdata != '0), "stamp writes a free marker")
  `ASSERT_CLK(a_fail_zero, clk_i, (out_valid_o && !granted_o) |-> (page_index_o == '0 && first_block_o == '0 && owner_id_o == '0), "failed beat carries nonzero fields")
  `ASSERT_RST(a_accept_drained, clk_i, rst_ni, (in_valid_i && !in_stall_o) |-> (!rd_vld_q && !id_vld_q), "request taken while memory reads in flight")

endmodule

// ----- src/ffba_ram.sv -----
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned NUM_PAGES   = DEF_PAGES;
  localparam int unsigned BLOCKS      = DEF_BLOCKS_PER_PAGE;
  localparam int unsigned ID_W        = DEF_ID_BITS;
  localparam int unsigned NUM_IDS     = 1 << ID_W;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned NUM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS = 74;
  localparam int unsigned NUM_ROWS    = 23;

  typedef struct packed {
    logic                   granted;
    logic [PAGE_OUT_W-1:0]  page;
    logic [BLOCK_OUT_W-1:0] first;
    logic [ID_OUT_W-1:0]    id;
  } grant_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  count;
    bit                typed;
    grant_t            want;
  } alloc_row_t;

  localparam grant_t NO_GRANT = '0;

  localparam logic [MASK_W-1:0] PHASE_MASKS [NUM_PHASES] =
    '{8'h0F, 8'h30, 8'h00, 8'hC0, 8'hA5, 8'hFF, 8'h5A};

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [MASK_W-1:0]      cfg_page_present_mask_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [CNT_W-1:0]       block_count_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   granted_o;
  logic [PAGE_OUT_W-1:0]  page_index_o;
  logic [BLOCK_OUT_W-1:0] first_block_o;
  logic [ID_OUT_W-1:0]    owner_id_o;

  // predictor state
  logic [ID_W-1:0]   owner_map [NUM_PAGES*BLOCKS] = '{default: '0};
  logic [MASK_W-1:0] present_pages = '0;

  grant_t      pending_grants [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;

  // rows with a typed result come straight from reset and the page layout so far
  alloc_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 7'd1,   1'b1, NO_GRANT},
    '{8'h00, 7'd0,   1'b1, NO_GRANT},
    '{8'h01, 7'd0,   1'b1, NO_GRANT},
    '{8'h01, 7'd65,  1'b1, NO_GRANT},
    '{8'h01, 7'd127, 1'b1, NO_GRANT},
    '{8'h01, 7'd1,   1'b1, '{1'b1, 3'd0, 6'd0, 10'd1}},
    '{8'h01, 7'd64,  1'b1, NO_GRANT},
    '{8'h01, 7'd63,  1'b1, '{1'b1, 3'd0, 6'd1, 10'd2}},
    '{8'h01, 7'd1,   1'b1, NO_GRANT},
    '{8'h02, 7'd64,  1'b1, '{1'b1, 3'd1, 6'd0, 10'd1}},
    '{8'h03, 7'd1,   1'b1, NO_GRANT},
    '{8'h80, 7'd5,   1'b1, '{1'b1, 3'd7, 6'd0, 10'd1}},
    '{8'h80, 7'd3,   1'b1, '{1'b1, 3'd7, 6'd5, 10'd2}},
    '{8'h84, 7'd2,   1'b1, '{1'b1, 3'd2, 6'd0, 10'd3}},
    '{8'h84, 7'd64,  1'b1, NO_GRANT},
    '{8'hFF, 7'd4,   1'b1, '{1'b1, 3'd2, 6'd2, 10'd4}},
    '{8'hFF, 7'd7,   1'b1, '{1'b1, 3'd2, 6'd6, 10'd5}},
    '{8'hFF, 7'd60,  1'b1, '{1'b1, 3'd3, 6'd0, 10'd6}},
    '{8'hFF, 7'd0,   1'b1, NO_GRANT},
    '{8'h7F, 7'd2,   1'b0, NO_GRANT},
    '{8'h7F, 7'd9,   1'b0, NO_GRANT},
    '{8'h80, 7'd2,   1'b0, NO_GRANT},
    '{8'hFF, 7'd1,   1'b0, NO_GRANT}
  };

  first_fit_block_run_allocator DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_page_present_mask_i(cfg_page_present_mask_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .block_count_i          (block_count_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .granted_o              (granted_o),
    .page_index_o           (page_index_o),
    .first_block_o          (first_block_o),
    .owner_id_o             (owner_id_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // first fit over the present pages, then the lowest id unused on them
  function automatic grant_t allocate_run(input logic [CNT_W-1:0] count);
    grant_t      res;
    bit          id_used [NUM_IDS];
    int unsigned run_len;
    int unsigned start;
    int unsigned page_hit;
    int unsigned new_id;
    bit          found;
    res   = NO_GRANT;
    found = 1'b0;
    if (count == 0 || count > BLOCKS) return res;
    for (int p = 0; p < NUM_PAGES && !found; p++) begin
      if (present_pages[p]) begin
        run_len = 0;
        for (int b = 0; b < BLOCKS && !found; b++) begin
          if (owner_map[p*BLOCKS+b] != '0) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == count) begin
              found    = 1'b1;
              page_hit = p;
              start    = b + 1 - count;
            end
          end
        end
      end
    end
    if (!found) return res;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (present_pages[p]) begin
        for (int b = 0; b < BLOCKS; b++) id_used[owner_map[p*BLOCKS+b]] = 1'b1;
      end
    end
    new_id = 0;
    for (int i = NUM_IDS - 1; i >= 1; i--) begin
      if (!id_used[i]) new_id = i;
    end
    if (new_id == 0) return res;
    for (int b = start; b < start + count; b++) owner_map[page_hit*BLOCKS+b] = ID_W'(new_id);
    res.granted = 1'b1;
    res.page    = PAGE_OUT_W'(page_hit);
    res.first   = BLOCK_OUT_W'(start);
    res.id      = ID_OUT_W'(new_id);
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %0d/%0d/%0d/%0d",
                 $time, granted_o, page_index_o, first_block_o, owner_id_o);
        error_count++;
      end else begin
        want = pending_grants.pop_front();
        compare_field("granted", 16'(want.granted), 16'(granted_o));
        compare_field("page_index", 16'(want.page), 16'(page_index_o));
        compare_field("first_block", 16'(want.first), 16'(first_block_o));
        compare_field("owner_id", 16'(want.id), 16'(owner_id_o));
      end
    end
  end

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return CNT_W'(1);
    if (sel < 65) return CNT_W'($urandom_range(4, 2));
    if (sel < 72) return CNT_W'($urandom_range(16, 5));
    if (sel < 75) return CNT_W'($urandom_range(63, 17));
    if (sel < 85) return CNT_W'(0);
    if (sel < 95) return CNT_W'($urandom_range(127, 65));
    return CNT_W'(BLOCKS);
  endfunction

  // valid stays up after a beat; the next call either reloads it or drops it for a gap
  task automatic send_request(input logic [CNT_W-1:0] count, input bit typed,
                              input grant_t want);
    grant_t predicted;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i    <= 1'b1;
    block_count_i <= count;
    do @(posedge clk_i); while (in_stall_o);
    predicted = allocate_run(count);
    pending_grants.push_back(typed ? want : predicted);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  task automatic set_page_mask(input logic [MASK_W-1:0] mask);
    drain_requests();
    cfg_valid_i             <= 1'b1;
    cfg_page_present_mask_i <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    present_pages  = mask;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mask != present_pages) set_page_mask(directed_rows[i].mask);
      send_request(directed_rows[i].count, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 58;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 58;
        end
        default: begin
          sender_idle_pct = 8;
          stall_pct       = 8;
        end
      endcase
      set_page_mask(ph == NUM_PHASES - 1 ? MASK_W'($urandom_range(255)) : PHASE_MASKS[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the block has answered everything
        if (ph == 1 && n == PHASE_ITEMS / 2) drain_requests();
        send_request(pick_count(), 1'b0, NO_GRANT);
      end
    end

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
